// ===== rtl/sreu_pkg.sv =====
// Shared types, opcodes and constants of the simple RISC execute unit.
package sreu_pkg;

	localparam int DATA_DEPTH_DEF = 1024;
	localparam int REG_COUNT_DEF = 32;
	localparam int PC_W = 10;

	localparam logic [4:0] OP_STOP = 5'd0;
	localparam logic [4:0] OP_ADD = 5'd1;
	localparam logic [4:0] OP_SUB = 5'd2;
	localparam logic [4:0] OP_MUL = 5'd3;
	localparam logic [4:0] OP_DIV = 5'd4;
	localparam logic [4:0] OP_AND = 5'd5;
	localparam logic [4:0] OP_OR = 5'd6;
	localparam logic [4:0] OP_XOR = 5'd7;
	localparam logic [4:0] OP_SHL = 5'd8;
	localparam logic [4:0] OP_SHR = 5'd9;
	localparam logic [4:0] OP_SLT = 5'd10;
	localparam logic [4:0] OP_SLE = 5'd11;
	localparam logic [4:0] OP_SEQ = 5'd12;
	localparam logic [4:0] OP_LOAD = 5'd13;
	localparam logic [4:0] OP_STORE = 5'd14;
	localparam logic [4:0] OP_JMP = 5'd15;
	localparam logic [4:0] OP_BRAZ = 5'd16;
	localparam logic [4:0] OP_BRANZ = 5'd17;
	localparam logic [4:0] OP_SCALL = 5'd18;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_SHOW = 3'd1;
	localparam logic [2:0] EV_USER = 3'd2;
	localparam logic [2:0] EV_STOP = 3'd3;
	localparam logic [2:0] EV_BAD = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;  // write one memory word to zero during the clearing pass
		logic load_item;   // capture the request and read source registers
		logic read_mem;    // issue data memory read
		logic start_div;   // start the iterative divider
		logic commit;      // write back and form the result
		logic skip;        // halted: form the held result only
	} sreu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic is_div;
		logic is_load;
		logic div_busy;
		logic stopped;     // stop or an unknown opcode has executed
	} sreu_sts_t;

endpackage

// ===== rtl/simple_risc_execute_unit.sv =====
// Top level of the simple RISC execute unit.
// Each request passes through the accept, execute, write-back and result states; a
// divide also waits in the divide state while the one-bit-per-cycle divider runs.
// Once halted, a request goes from accept straight to the result state. No new
// request is taken until the result of the last one has been taken at the output.
// After reset a clearing pass zeroes data memory, one word a cycle; no request is
// taken until it ends. Register file and pc reset to zero.
module simple_risc_execute_unit #(
	parameter int DATA_DEPTH = sreu_pkg::DATA_DEPTH_DEF,
	parameter int REG_COUNT = sreu_pkg::REG_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instruction_word,
	input  logic signed [31:0] user_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         next_pc,
	output logic               halted,
	output logic [2:0]         event_code,
	output logic [4:0]         shown_index,
	output logic signed [31:0] shown_value
);

	sreu_pkg::sreu_cmd_t cmd;
	sreu_pkg::sreu_sts_t sts;

	// The controller sequences each request; the stopped state comes back from the
	// datapath as status, so requests after a halt only produce the held result.
	sreu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	sreu_datapath #(.DATA_DEPTH(DATA_DEPTH), .REG_COUNT(REG_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.instruction_word(instruction_word), .user_value(user_value),
		.next_pc(next_pc), .halted(halted), .event_code(event_code),
		.shown_index(shown_index), .shown_value(shown_value)
	);

endmodule

// ===== rtl/sreu_divider.sv =====
// Iterative signed divider, one quotient bit per cycle.
module sreu_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);

	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        neg_q, zero_q, busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
			zero_q <= (divisor == 32'd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Overflow case falls out naturally: the magnitude 2^31 negates to itself.
	assign quotient = zero_q ? 32'hFFFF_FFFF : (neg_q ? (32'd0 - quo_q) : quo_q);

endmodule

// ===== rtl/sreu_datapath.sv =====
// Datapath: register file, data memory, ALU, divider and result registers.
module sreu_datapath #(
	parameter int DATA_DEPTH = sreu_pkg::DATA_DEPTH_DEF,
	parameter int REG_COUNT = sreu_pkg::REG_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sreu_pkg::sreu_cmd_t     cmd,
	output sreu_pkg::sreu_sts_t     sts,
	input  logic [31:0]             instruction_word,
	input  logic signed [31:0]      user_value,
	output logic [sreu_pkg::PC_W-1:0] next_pc,
	output logic                    halted,
	output logic [2:0]              event_code,
	output logic [4:0]              shown_index,
	output logic signed [31:0]      shown_value
);

	localparam int AW = $clog2(DATA_DEPTH);
	localparam int RW = $clog2(REG_COUNT);

	logic [31:0] rf_q [REG_COUNT];
	logic [31:0] mem_q [DATA_DEPTH];
	logic [AW-1:0] clr_q;
	logic [sreu_pkg::PC_W-1:0] pc_q;
	logic stop_q;

	logic [31:0] ir_s1, av_s1, op_s1, bv_s1, user_s1, mem_s2, mul_s2;
	logic [4:0] opc;
	logic [31:0] quo;
	logic div_busy;
	logic [31:0] addr_sum;
	logic [sreu_pkg::PC_W-1:0] pc_inc;

	assign opc = ir_s1[31:27];
	assign addr_sum = av_s1 + op_s1;
	assign pc_inc = pc_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ir_s1 <= instruction_word;
			user_s1 <= user_value;
			av_s1 <= rf_q[instruction_word[22+RW-1:22]];
			bv_s1 <= rf_q[instruction_word[RW-1:0]];
			op_s1 <= instruction_word[21] ? {{16{instruction_word[20]}}, instruction_word[20:5]}
				: rf_q[instruction_word[5+RW-1:5]];
		end
		mul_s2 <= av_s1 * op_s1;
	end

	sreu_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start_div),
		.dividend(av_s1), .divisor(op_s1), .busy(div_busy), .quotient(quo)
	);

	// Memory: one write port (clear or store), one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem_q[clr_q] <= '0;
		end else if (cmd.commit && opc == sreu_pkg::OP_STORE) begin
			mem_q[addr_sum[AW-1:0]] <= bv_s1;
		end
		if (cmd.read_mem) begin
			mem_s2 <= mem_q[addr_sum[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clear_done = (clr_q == AW'(DATA_DEPTH - 1));
	assign sts.is_div = (opc == sreu_pkg::OP_DIV);
	assign sts.is_load = (opc == sreu_pkg::OP_LOAD);
	assign sts.div_busy = div_busy;
	assign sts.stopped = stop_q;

	logic [31:0] res;
	logic        wr;
	logic [sreu_pkg::PC_W-1:0] npc;
	logic [2:0]  ev;
	logic        stp;
	logic [31:0] tgt;
	logic [4:0]  sidx;

	always_comb begin
		res = '0;
		wr = 1'b1;
		npc = pc_inc;
		ev = sreu_pkg::EV_NONE;
		stp = 1'b0;
		tgt = ir_s1[26] ? {12'd0, ir_s1[24:5]} : rf_q[ir_s1[5+RW-1:5]];
		sidx = ir_s1[4:0];
		unique case (opc)
			sreu_pkg::OP_ADD: res = addr_sum;
			sreu_pkg::OP_SUB: res = av_s1 - op_s1;
			sreu_pkg::OP_MUL: res = mul_s2;
			sreu_pkg::OP_DIV: res = quo;
			sreu_pkg::OP_AND: res = av_s1 & op_s1;
			sreu_pkg::OP_OR: res = av_s1 | op_s1;
			sreu_pkg::OP_XOR: res = av_s1 ^ op_s1;
			sreu_pkg::OP_SHL: res = av_s1 << op_s1[4:0];
			sreu_pkg::OP_SHR: res = $unsigned($signed(av_s1) >>> op_s1[4:0]);
			sreu_pkg::OP_SLT: res = {31'd0, $signed(av_s1) < $signed(op_s1)};
			sreu_pkg::OP_SLE: res = {31'd0, $signed(av_s1) <= $signed(op_s1)};
			sreu_pkg::OP_SEQ: res = {31'd0, av_s1 == op_s1};
			sreu_pkg::OP_LOAD: res = mem_s2;
			sreu_pkg::OP_STORE: wr = 1'b0;
			sreu_pkg::OP_JMP: begin
				npc = tgt[sreu_pkg::PC_W-1:0];
				res = {22'd0, pc_inc};
				wr = (ir_s1[4:0] != 5'd0);
			end
			sreu_pkg::OP_BRAZ: begin
				wr = 1'b0;
				if (av_s1 == 32'd0) npc = ir_s1[sreu_pkg::PC_W-1:0];
			end
			sreu_pkg::OP_BRANZ: begin
				wr = 1'b0;
				if (av_s1 != 32'd0) npc = ir_s1[sreu_pkg::PC_W-1:0];
			end
			sreu_pkg::OP_SCALL: begin
				wr = 1'b0;
				ev = (ir_s1[26:0] != 27'd0) ? sreu_pkg::EV_SHOW : sreu_pkg::EV_USER;
			end
			sreu_pkg::OP_STOP: begin
				wr = 1'b0;
				stp = 1'b1;
				ev = sreu_pkg::EV_STOP;
			end
			default: begin
				wr = 1'b0;
				stp = 1'b1;
				ev = sreu_pkg::EV_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
			pc_q <= '0;
			stop_q <= 1'b0;
		end else if (cmd.commit) begin
			if (wr) rf_q[ir_s1[RW-1:0]] <= res;
			if (ev == sreu_pkg::EV_USER) rf_q[1] <= user_s1;
			pc_q <= npc;
			stop_q <= stp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_pc <= npc;
			halted <= stp;
			event_code <= ev;
			shown_index <= (ev == sreu_pkg::EV_SHOW) ? sidx : 5'd0;
			shown_value <= (ev == sreu_pkg::EV_SHOW) ? rf_q[sidx[RW-1:0]] : 32'd0;
		end else if (cmd.skip) begin
			next_pc <= pc_q;
			halted <= 1'b1;
			event_code <= sreu_pkg::EV_NONE;
			shown_index <= '0;
			shown_value <= '0;
		end
	end

endmodule

// ===== rtl/sreu_ctrl.sv =====
// Controller state machine: clearing pass, item sequencing and handshake.
module sreu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sreu_pkg::sreu_sts_t sts,
	output sreu_pkg::sreu_cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_WB = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q;
	logic       acc;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.clear_step = (state_q == S_CLEAR);
		cmd.load_item = acc && !sts.stopped;
		cmd.skip = acc && sts.stopped;
		cmd.read_mem = (state_q == S_EXEC);
		cmd.start_div = (state_q == S_EXEC) && sts.is_div;
		cmd.commit = (state_q == S_WB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clear_done) state_q <= S_IDLE;
				S_IDLE: if (acc) state_q <= sts.stopped ? S_OUT : S_EXEC;
				S_EXEC: state_q <= sts.is_div ? S_DIV : S_WB;
				S_DIV: if (!sts.div_busy) state_q <= S_WB;
				S_WB: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("ready while busy");
	a_commit_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("commit not followed by result");
	a_div_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_busy) |=> !out_valid) else $error("early div result");

endmodule

// ===== dv/simple_risc_execute_unit_tb.sv =====
// Testbench for the simple RISC execute unit: directed table, then random programs.
module simple_risc_execute_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// Number of random requests after the directed table.
	localparam int RANDOM_COUNT = 1500;
	// Cycles with no handshake on either side before the run is abandoned.
	// It covers the memory clearing pass after reset, a divide and the longest stalls.
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	// One result as the block reports it.
	typedef struct packed {
		logic [9:0]  pc;
		logic        halted;
		logic [2:0]  ev;
		logic [4:0]  idx;
		logic [31:0] val;
	} outcome_t;

	// One row of the directed table. When has_typed is set, the expected result is
	// the typed one rather than the predictor's.
	typedef struct {
		logic [31:0] word;
		logic [31:0] user;
		bit          has_typed;
		outcome_t    typed;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        instruction_word = '0;
	logic signed [31:0] user_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [9:0]         next_pc;
	logic               halted;
	logic [2:0]         event_code;
	logic [4:0]         shown_index;
	logic signed [31:0] shown_value;

	simple_risc_execute_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.instruction_word(instruction_word),
		.user_value(user_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_pc(next_pc),
		.halted(halted),
		.event_code(event_code),
		.shown_index(shown_index),
		.shown_value(shown_value)
	);

	always #4 clk = ~clk;

	// Machine state as the predictor sees it.
	logic [31:0] mirror_regs [32];
	logic [31:0] mirror_mem [1024];
	logic [9:0]  mirror_pc;
	bit          mirror_stopped;

	outcome_t pending_results[$];
	int       mismatch_count = 0;
	int       idle_cycles = 0;
	// While set, neither side inserts gaps, so back-to-back traffic is also seen.
	bit       no_idling = 1'b0;

	// Executes one instruction on the mirror state and returns what the block must report.
	function automatic outcome_t execute_instruction(input logic [31:0] w, input logic [31:0] user);
		outcome_t    o;
		logic [4:0]  op;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] res;
		logic [31:0] tgt;
		logic [9:0]  addr;
		bit          wr;
		o = '0;
		if (!mirror_stopped) begin
			op = w[31:27];
			ra = w[26:22];
			rb = w[4:0];
			a = mirror_regs[ra];
			b = w[21] ? {{16{w[20]}}, w[20:5]} : mirror_regs[w[9:5]];
			addr = 10'(a + b);
			res = '0;
			wr = 1'b1;
			mirror_pc = mirror_pc + 10'd1;
			case (op)
				sreu_pkg::OP_ADD: res = a + b;
				sreu_pkg::OP_SUB: res = a - b;
				sreu_pkg::OP_MUL: res = a * b;
				sreu_pkg::OP_DIV: begin
					// Divide by zero gives all ones; the overflow case keeps the dividend.
					if (b == 0)
						res = 32'hFFFF_FFFF;
					else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
						res = 32'h8000_0000;
					else
						res = $signed(a) / $signed(b);
				end
				sreu_pkg::OP_AND: res = a & b;
				sreu_pkg::OP_OR: res = a | b;
				sreu_pkg::OP_XOR: res = a ^ b;
				sreu_pkg::OP_SHL: res = a << b[4:0];
				sreu_pkg::OP_SHR: res = $signed(a) >>> b[4:0];
				sreu_pkg::OP_SLT: res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				sreu_pkg::OP_SLE: res = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
				sreu_pkg::OP_SEQ: res = (a == b) ? 32'd1 : 32'd0;
				sreu_pkg::OP_LOAD: res = mirror_mem[addr];
				sreu_pkg::OP_STORE: begin
					mirror_mem[addr] = mirror_regs[rb];
					wr = 1'b0;
				end
				sreu_pkg::OP_JMP: begin
					// Bit 26 picks the immediate target over a register target.
					tgt = w[26] ? {12'd0, w[24:5]} : mirror_regs[w[9:5]];
					if (rb != 0)
						mirror_regs[rb] = {22'd0, mirror_pc};
					mirror_pc = tgt[9:0];
					wr = 1'b0;
				end
				sreu_pkg::OP_BRAZ: begin
					if (a == 0)
						mirror_pc = w[9:0];
					wr = 1'b0;
				end
				sreu_pkg::OP_BRANZ: begin
					if (a != 0)
						mirror_pc = w[9:0];
					wr = 1'b0;
				end
				sreu_pkg::OP_SCALL: begin
					if (w[26:0] != 0) begin
						o.ev = sreu_pkg::EV_SHOW;
						o.idx = w[4:0];
						o.val = mirror_regs[w[4:0]];
					end else begin
						o.ev = sreu_pkg::EV_USER;
						mirror_regs[1] = user;
					end
					wr = 1'b0;
				end
				sreu_pkg::OP_STOP: begin
					mirror_stopped = 1'b1;
					o.ev = sreu_pkg::EV_STOP;
					wr = 1'b0;
				end
				default: begin
					mirror_stopped = 1'b1;
					o.ev = sreu_pkg::EV_BAD;
					wr = 1'b0;
				end
			endcase
			if (wr)
				mirror_regs[rb] = res;
		end
		o.pc = mirror_pc;
		o.halted = mirror_stopped;
		return o;
	endfunction

	function automatic logic [31:0] enc_alu(input logic [4:0] op, input logic [4:0] ra,
			input bit imm, input logic [15:0] operand, input logic [4:0] rb);
		return {op, ra, imm, operand, rb};
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got 0x%08h, expected 0x%08h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Draws a random instruction for the bulk of the run; stop and unknown opcodes are
	// left out because they would halt the machine for good.
	function automatic logic [31:0] random_instruction();
		logic [31:0] w;
		int          pick;
		w = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 65)
			w[31:27] = 5'($urandom_range(int'(sreu_pkg::OP_ADD), int'(sreu_pkg::OP_SEQ)));
		else if (pick < 78)
			w[31:27] = ($urandom_range(0, 1) != 0) ? sreu_pkg::OP_LOAD : sreu_pkg::OP_STORE;
		else if (pick < 90)
			w[31:27] = 5'($urandom_range(int'(sreu_pkg::OP_JMP), int'(sreu_pkg::OP_BRANZ)));
		else
			w[31:27] = sreu_pkg::OP_SCALL;
		// Keep register-read dependencies dense and reach the operand extremes now and then.
		if ($urandom_range(0, 3) == 0)
			w[9:5] = w[4:0];
		case ($urandom_range(0, 9))
			0: w[20:5] = 16'h7FFF;
			1: w[20:5] = 16'h8000;
			2: w[20:5] = 16'hFFFF;
			default: ;
		endcase
		if (w[31:27] == sreu_pkg::OP_SCALL && $urandom_range(0, 3) == 0)
			w[26:0] = '0;
		return w;
	endfunction

	function automatic logic [31:0] random_user();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Presents one request and waits for the handshake; the expectation is queued on accept.
	task automatic send_request(input logic [31:0] w, input logic [31:0] user,
			input bit has_typed, input outcome_t typed);
		int       gap;
		outcome_t predicted;
		gap = no_idling ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		user_value <= user;
		do @(posedge clk); while (!in_ready);
		predicted = execute_instruction(w, user);
		pending_results.push_back(has_typed ? typed : predicted);
	endtask

	// Result side: checks every accepted result and draws the stall before the next one.
	int stall_left = 0;
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		int       n;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{next_pc, halted, event_code, shown_index, shown_value};
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, next_pc", {22'd0, got.pc}, 32'd0);
				end else begin
					want = pending_results.pop_front();
					if (got.pc !== want.pc)
						report_mismatch("next_pc", {22'd0, got.pc}, {22'd0, want.pc});
					if (got.halted !== want.halted)
						report_mismatch("halted", {31'd0, got.halted}, {31'd0, want.halted});
					if (got.ev !== want.ev)
						report_mismatch("event_code", {29'd0, got.ev}, {29'd0, want.ev});
					if (got.idx !== want.idx)
						report_mismatch("shown_index", {27'd0, got.idx}, {27'd0, want.idx});
					if (got.val !== want.val)
						report_mismatch("shown_value", got.val, want.val);
				end
				n = no_idling ? 0 : $urandom_range(0, 6);
				stall_left = (n > 0) ? n - 1 : 0;
				out_ready <= (n == 0);
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: any handshake resets the count of quiet cycles.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simple_risc_execute_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t directed[$];
		stim_row_t row;
		outcome_t  none;
		logic [31:0] w;
		int i;
		none = '0;
		foreach (mirror_regs[k]) mirror_regs[k] = '0;
		foreach (mirror_mem[k]) mirror_mem[k] = '0;
		mirror_pc = '0;
		mirror_stopped = 1'b0;

		// Directed table. Rows with a typed result come right after reset, where the
		// machine state is known by inspection.
		directed.push_back('{enc_alu(sreu_pkg::OP_ADD, 5'd0, 1'b1, 16'h7FFF, 5'd2), 32'd0,
			1'b1, '{10'd1, 1'b0, sreu_pkg::EV_NONE, 5'd0, 32'd0}});
		// A nonzero scall index wraps modulo 32, so index 32 shows r0.
		directed.push_back('{{sreu_pkg::OP_SCALL, 27'd32}, 32'd0, 1'b1,
			'{10'd2, 1'b0, sreu_pkg::EV_SHOW, 5'd0, 32'd0}});
		// Index zero takes the user value into r1.
		directed.push_back('{{sreu_pkg::OP_SCALL, 27'd0}, 32'h8000_0000, 1'b1,
			'{10'd3, 1'b0, sreu_pkg::EV_USER, 5'd0, 32'd0}});
		directed.push_back('{{sreu_pkg::OP_SCALL, 27'h7FF_FFFF}, 32'd0, 1'b1,
			'{10'd4, 1'b0, sreu_pkg::EV_SHOW, 5'd31, 32'd0}});
		// Negative immediate is sign-extended.
		directed.push_back('{enc_alu(sreu_pkg::OP_ADD, 5'd0, 1'b1, 16'h8000, 5'd3), 32'd0,
			0, none});
		// Divide overflow: the most negative value over minus one.
		directed.push_back('{enc_alu(sreu_pkg::OP_DIV, 5'd1, 1'b1, 16'hFFFF, 5'd5), 32'd0,
			0, none});
		// Divide by zero through a register operand.
		directed.push_back('{enc_alu(sreu_pkg::OP_DIV, 5'd2, 1'b0, 16'd0, 5'd6), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_DIV, 5'd3, 1'b1, 16'd7, 5'd8), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_SUB, 5'd0, 1'b0, 16'd1, 5'd4), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_MUL, 5'd2, 1'b0, 16'd2, 5'd7), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_AND, 5'd3, 1'b1, 16'hF0F0, 5'd9), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_OR, 5'd3, 1'b0, 16'd2, 5'd10), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_XOR, 5'd1, 1'b1, 16'hFFFF, 5'd11), 32'd0,
			0, none});
		// Shifts use only the low five bits of the amount; shr keeps the sign.
		directed.push_back('{enc_alu(sreu_pkg::OP_SHL, 5'd2, 1'b1, 16'h003F, 5'd12), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_SHR, 5'd1, 1'b1, 16'h001F, 5'd13), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_SLT, 5'd1, 1'b0, 16'd2, 5'd14), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_SLE, 5'd2, 1'b0, 16'd2, 5'd15), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_SEQ, 5'd3, 1'b1, 16'h8000, 5'd16), 32'd0,
			0, none});
		// Store and load through an address sum that wraps past the memory depth.
		directed.push_back('{enc_alu(sreu_pkg::OP_STORE, 5'd2, 1'b1, 16'h7FFF, 5'd1), 32'd0,
			0, none});
		directed.push_back('{enc_alu(sreu_pkg::OP_LOAD, 5'd2, 1'b1, 16'h7FFF, 5'd17), 32'd0,
			0, none});
		// Jump with an immediate target and a link, then through a register.
		directed.push_back('{{sreu_pkg::OP_JMP, 1'b1, 1'b1, 20'hFFFFF, 5'd18}, 32'd0,
			0, none});
		directed.push_back('{{sreu_pkg::OP_JMP, 1'b0, 1'b0, 20'd18, 5'd0}, 32'd0, 0, none});
		directed.push_back('{{sreu_pkg::OP_BRAZ, 5'd0, 22'h3FFFFF}, 32'd0, 0, none});
		directed.push_back('{{sreu_pkg::OP_BRANZ, 5'd0, 22'h155}, 32'd0, 0, none});
		directed.push_back('{{sreu_pkg::OP_BRANZ, 5'd1, 22'h2AA}, 32'h7FFF_FFFF, 0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			row = directed[k];
			send_request(row.word, row.user, row.has_typed, row.has_typed ? row.typed : none);
		end

		// Random programs; every few hundred requests a stretch without idling.
		for (i = 0; i < RANDOM_COUNT; i++) begin
			no_idling = ((i / 150) % 4 == 3);
			send_request(random_instruction(), random_user(), 1'b0, none);
		end
		no_idling = 1'b0;

		// Halt the machine, by stop or by an unknown opcode, and check that further
		// requests are ignored.
		w = $urandom();
		w[31:27] = ($urandom_range(0, 1) != 0) ? sreu_pkg::OP_STOP : 5'($urandom_range(19, 31));
		send_request(w, random_user(), 1'b0, none);
		for (i = 0; i < 6; i++) begin
			w = random_instruction();
			if (i == 0)
				w[31:27] = sreu_pkg::OP_STOP;
			send_request(w, random_user(), 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simple_risc_execute_unit_tb: PASS");
		else
			$display("simple_risc_execute_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sreu_pkg.sv
rtl/sreu_divider.sv
rtl/sreu_datapath.sv
rtl/sreu_ctrl.sv
rtl/simple_risc_execute_unit.sv
dv/simple_risc_execute_unit_tb.sv
